[src/ffcba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ffcba_pkg;

  // pool geometry
  localparam int NODE_COUNT = 16384;
  localparam int NODE_BYTES = 64;

  // stream field widths
  localparam int BYTES_W  = 21;
  localparam int FI_W     = 14;
  localparam int START_W  = 14;
  localparam int COUNT_W  = 15;
  localparam int STATUS_W = 2;

  // node map storage: one row holds the used bits of WORD_W nodes
  localparam int WORD_W    = 64;
  localparam int WORD_LG   = 6;
  localparam int CHUNK_W   = 8;
  localparam int CHUNK_LG  = 3;
  localparam int SB_W      = WORD_LG - CHUNK_LG;
  localparam int ROWS      = (NODE_COUNT + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_ROW  = ROWS - 1;
  localparam int LAST_BITS = NODE_COUNT - LAST_ROW * WORD_W;
  localparam int IX_W      = ROW_W + WORD_LG;
  localparam int SPAN_W    = IX_W + 1;
  localparam int IDX_W     = $clog2(NODE_COUNT);
  localparam int CNT_W     = $clog2(NODE_COUNT + 1);

  // rounded node count before the range check
  localparam int NEED_W = BYTES_W + 1;

  // command queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NOSPACE  = 2'd2,
    ST_NOTSTART = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_ZERO,
    CMD_BIG
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [CNT_W-1:0]  need;
    logic [FI_W-1:0]   idx;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLASS,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_SCAN,
    B_FREE_CHK,
    B_MARK_RD,
    B_MARK_WR,
    B_DONE
  } back_state_t;

  // bits of the last row that lie past the end of the pool read as used
  function automatic logic [WORD_W-1:0] pad_mask();
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (i >= LAST_BITS);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[src/ffcba_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffcba_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              enable,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              func,
  input  wire logic [ffcba_pkg::BYTES_W-1:0]     size_bytes,
  input  wire logic [ffcba_pkg::FI_W-1:0]        free_index,
  output logic                                   cmd_valid,
  input  wire logic                              cmd_ready,
  output ffcba_pkg::cmd_t                        cmd
);

  ffcba_pkg::front_state_t state, state_next;
  logic [ffcba_pkg::BYTES_W-1:0] q, q_next;
  ffcba_pkg::cmd_t               cmd_r, cmd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffcba_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
    q     <= q_next;
    cmd_r <= cmd_next;
  end

  always_comb begin
    logic [ffcba_pkg::NEED_W-1:0] need;
    state_next = state;
    q_next     = q;
    cmd_next   = cmd_r;
    in_ready   = 1'b0;
    cmd_valid  = 1'b0;
    // node size is a power of two: shift and mask
    need       = ffcba_pkg::NEED_W'(q / ffcba_pkg::NODE_BYTES) +
                 ffcba_pkg::NEED_W'((q % ffcba_pkg::NODE_BYTES) != 0);
    case (state)
      ffcba_pkg::F_IDLE: begin
        in_ready = enable;
        if (in_valid && enable) begin
          cmd_next.idx  = free_index;
          cmd_next.need = '0;
          if (func) begin
            cmd_next.op = ffcba_pkg::CMD_FREE;
            state_next  = ffcba_pkg::F_PUSH;
          end else begin
            q_next     = size_bytes;
            state_next = ffcba_pkg::F_CLASS;
          end
        end
      end
      ffcba_pkg::F_CLASS: begin
        // round up to whole nodes, then sort out requests that cannot fit
        cmd_next.need = ffcba_pkg::CNT_W'(need);
        if (need == '0) begin
          cmd_next.op = ffcba_pkg::CMD_ZERO;
        end else if (need > ffcba_pkg::NEED_W'(ffcba_pkg::NODE_COUNT)) begin
          cmd_next.op = ffcba_pkg::CMD_BIG;
        end else begin
          cmd_next.op = ffcba_pkg::CMD_ALLOC;
        end
        state_next = ffcba_pkg::F_PUSH;
      end
      ffcba_pkg::F_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          state_next = ffcba_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = ffcba_pkg::F_IDLE;
      end
    endcase
  end

  assign cmd = cmd_r;

endmodule
`default_nettype wire

[src/ffcba_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffcba_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire ffcba_pkg::cmd_t   push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output ffcba_pkg::cmd_t        pop_data
);

  ffcba_pkg::cmd_t                entries [ffcba_pkg::QUEUE_DEPTH];
  logic [ffcba_pkg::QP_W-1:0]     wp, rp;
  logic [ffcba_pkg::QC_W-1:0]     cnt;
  logic                           do_push, do_pop;

  assign push_ready = (cnt != ffcba_pkg::QC_W'(ffcba_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = entries[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (do_push) begin
      entries[wp] <= push_data;
    end
  end

endmodule
`default_nettype wire

[src/ffcba_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffcba_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  output logic                                  init_done,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire ffcba_pkg::cmd_t                  cmd,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output ffcba_pkg::status_t                    out_status,
  output logic [ffcba_pkg::START_W-1:0]         out_start,
  output logic [ffcba_pkg::COUNT_W-1:0]         out_count
);

  localparam int IX_W   = ffcba_pkg::IX_W;
  localparam int SPAN_W = ffcba_pkg::SPAN_W;
  localparam int ROW_W  = ffcba_pkg::ROW_W;
  localparam int IDX_W  = ffcba_pkg::IDX_W;
  localparam int CNT_W  = ffcba_pkg::CNT_W;
  localparam int WORD_W = ffcba_pkg::WORD_W;
  localparam int WLG    = ffcba_pkg::WORD_LG;
  localparam int SB_W   = ffcba_pkg::SB_W;
  localparam logic [WORD_W-1:0] PAD = ffcba_pkg::pad_mask();

  // node map rows and run lengths
  logic [WORD_W-1:0] used_mem [ffcba_pkg::ROWS];
  logic [CNT_W-1:0]  run_mem  [ffcba_pkg::NODE_COUNT];

  logic              u_rd_en, u_we;
  logic [ROW_W-1:0]  u_ra, u_wa;
  logic [WORD_W-1:0] u_wd, row_q;
  logic              l_rd_en, l_we;
  logic [IDX_W-1:0]  l_ra, l_wa;
  logic [CNT_W-1:0]  l_wd, run_q;

  ffcba_pkg::back_state_t state, state_next;
  logic [IDX_W-1:0]   ic, ic_next;
  logic [ROW_W-1:0]   r, r_next, cur, cur_next;
  logic [SB_W-1:0]    sb, sb_next;
  logic [SPAN_W-1:0]  span, span_next, need, need_next;
  logic [IX_W-1:0]    lo, lo_next, hi, hi_next;
  logic               set_mode, set_mode_next;
  ffcba_pkg::status_t res_status, res_status_next;
  logic [IX_W-1:0]    res_start, res_start_next;
  logic [SPAN_W-1:0]  res_count, res_count_next;
  logic               out_valid_next;
  ffcba_pkg::status_t out_status_next;
  logic [ffcba_pkg::START_W-1:0] out_start_next;
  logic [ffcba_pkg::COUNT_W-1:0] out_count_next;

  always_ff @(posedge clk) begin
    if (u_we) begin
      used_mem[u_wa] <= u_wd;
    end
    if (u_rd_en) begin
      row_q <= used_mem[u_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      run_mem[l_wa] <= l_wd;
    end
    if (l_rd_en) begin
      run_q <= run_mem[l_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffcba_pkg::B_INIT;
      ic        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ic        <= ic_next;
      out_valid <= out_valid_next;
    end
    r          <= r_next;
    cur        <= cur_next;
    sb         <= sb_next;
    span       <= span_next;
    need       <= need_next;
    lo         <= lo_next;
    hi         <= hi_next;
    set_mode   <= set_mode_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
    res_count  <= res_count_next;
    out_status <= out_status_next;
    out_start  <= out_start_next;
    out_count  <= out_count_next;
  end

  assign init_done = (state != ffcba_pkg::B_INIT);

  always_comb begin
    logic [WORD_W-1:0]  masked, mask;
    logic [ffcba_pkg::CHUNK_W-1:0] chunk;
    logic [SPAN_W-1:0]  s, len, lim, end_ix, start_ix, hi_w;
    logic [ffcba_pkg::CHUNK_LG-1:0] fb;
    logic               fnd, advance;
    logic [IX_W-1:0]    nb;

    state_next      = state;
    ic_next         = ic;
    r_next          = r;
    cur_next        = cur;
    sb_next         = sb;
    span_next       = span;
    need_next       = need;
    lo_next         = lo;
    hi_next         = hi;
    set_mode_next   = set_mode;
    res_status_next = res_status;
    res_start_next  = res_start;
    res_count_next  = res_count;
    out_valid_next  = out_valid && !out_ready;
    out_status_next = out_status;
    out_start_next  = out_start;
    out_count_next  = out_count;
    cmd_ready       = 1'b0;
    u_rd_en = 1'b0;  u_ra = r;  u_we = 1'b0;  u_wa = cur;  u_wd = row_q;
    l_rd_en = 1'b0;  l_ra = lo[IDX_W-1:0];  l_we = 1'b0;  l_wa = lo[IDX_W-1:0];  l_wd = '0;

    masked   = row_q | ((r == ROW_W'(ffcba_pkg::LAST_ROW)) ? PAD : '0);
    chunk    = ffcba_pkg::CHUNK_W'(masked >> {sb, {ffcba_pkg::CHUNK_LG{1'b0}}});
    s        = span;
    fnd      = 1'b0;
    fb       = '0;
    advance  = 1'b0;
    len      = '0;
    lim      = '0;
    end_ix   = '0;
    start_ix = '0;
    hi_w     = '0;
    mask     = '0;
    nb       = '0;

    case (state)
      ffcba_pkg::B_INIT: begin
        // clearing pass: one run-length entry per cycle, plus one map row per cycle until every row is clear
        l_we = 1'b1;
        l_wa = ic;
        l_wd = '0;
        if ((IDX_W + 1)'(ic) < (IDX_W + 1)'(ffcba_pkg::ROWS)) begin
          u_we = 1'b1;
          u_wa = ROW_W'(ic);
          u_wd = '0;
        end
        if (ic == IDX_W'(ffcba_pkg::NODE_COUNT - 1)) begin
          state_next = ffcba_pkg::B_IDLE;
        end else begin
          ic_next = ic + 1'b1;
        end
      end
      ffcba_pkg::B_IDLE: begin
        if (cmd_valid) begin
          cmd_ready       = 1'b1;
          res_start_next  = '0;
          res_count_next  = '0;
          case (cmd.op)
            ffcba_pkg::CMD_ZERO: begin
              res_status_next = ffcba_pkg::ST_ZERO;
              state_next      = ffcba_pkg::B_DONE;
            end
            ffcba_pkg::CMD_BIG: begin
              res_status_next = ffcba_pkg::ST_NOSPACE;
              state_next      = ffcba_pkg::B_DONE;
            end
            ffcba_pkg::CMD_ALLOC: begin
              need_next  = SPAN_W'(cmd.need);
              r_next     = '0;
              sb_next    = '0;
              span_next  = '0;
              u_rd_en    = 1'b1;
              u_ra       = '0;
              state_next = ffcba_pkg::B_SCAN;
            end
            ffcba_pkg::CMD_FREE: begin
              if (32'(cmd.idx) >= ffcba_pkg::NODE_COUNT) begin
                res_status_next = ffcba_pkg::ST_NOTSTART;
                state_next      = ffcba_pkg::B_DONE;
              end else begin
                lo_next    = IX_W'(cmd.idx);
                l_rd_en    = 1'b1;
                l_ra       = IDX_W'(cmd.idx);
                state_next = ffcba_pkg::B_FREE_CHK;
              end
            end
            default: begin
              state_next = ffcba_pkg::B_IDLE;
            end
          endcase
        end
      end
      ffcba_pkg::B_SCAN: begin
        if (sb == '0 && (&masked)) begin
          span_next = '0;
          advance   = 1'b1;
        end else if (sb == '0 && !(|masked) &&
                     (span + SPAN_W'(WORD_W)) < need) begin
          span_next = span + SPAN_W'(WORD_W);
          advance   = 1'b1;
        end else begin
          // one byte of the map per cycle, free-run length carried along
          for (int b = 0; b < ffcba_pkg::CHUNK_W; b++) begin
            if (!fnd) begin
              if (chunk[b]) begin
                s = '0;
              end else begin
                s = s + 1'b1;
                if (s == need) begin
                  fnd = 1'b1;
                  fb  = ffcba_pkg::CHUNK_LG'(b);
                end
              end
            end
          end
          if (fnd) begin
            end_ix          = SPAN_W'({r, sb, fb});
            start_ix        = end_ix + 1'b1 - need;
            lo_next         = IX_W'(start_ix);
            hi_next         = IX_W'(end_ix);
            set_mode_next   = 1'b1;
            res_status_next = ffcba_pkg::ST_OK;
            res_start_next  = IX_W'(start_ix);
            res_count_next  = need;
            state_next      = ffcba_pkg::B_MARK_RD;
          end else begin
            span_next = s;
            if (sb == {SB_W{1'b1}}) begin
              advance = 1'b1;
            end else begin
              sb_next = sb + 1'b1;
            end
          end
        end
        if (advance) begin
          sb_next = '0;
          if (r == ROW_W'(ffcba_pkg::LAST_ROW)) begin
            res_status_next = ffcba_pkg::ST_NOSPACE;
            state_next      = ffcba_pkg::B_DONE;
          end else begin
            r_next  = r + 1'b1;
            u_rd_en = 1'b1;
            u_ra    = r + 1'b1;
          end
        end
      end
      ffcba_pkg::B_FREE_CHK: begin
        if (run_q == '0) begin
          res_status_next = ffcba_pkg::ST_NOTSTART;
          state_next      = ffcba_pkg::B_DONE;
        end else begin
          lim = SPAN_W'(ffcba_pkg::NODE_COUNT) - SPAN_W'(lo);
          len = (SPAN_W'(run_q) > lim) ? lim : SPAN_W'(run_q);
          hi_w            = SPAN_W'(lo) + len - 1'b1;
          hi_next         = IX_W'(hi_w);
          cur_next        = lo[IX_W-1:WLG];
          set_mode_next   = 1'b0;
          res_status_next = ffcba_pkg::ST_OK;
          res_start_next  = lo;
          res_count_next  = len;
          u_rd_en         = 1'b1;
          u_ra            = lo[IX_W-1:WLG];
          state_next      = ffcba_pkg::B_MARK_WR;
        end
      end
      ffcba_pkg::B_MARK_RD: begin
        cur_next   = lo[IX_W-1:WLG];
        u_rd_en    = 1'b1;
        u_ra       = lo[IX_W-1:WLG];
        state_next = ffcba_pkg::B_MARK_WR;
      end
      ffcba_pkg::B_MARK_WR: begin
        // read-modify-write of one row a cycle; next row is read meanwhile
        for (int b = 0; b < WORD_W; b++) begin
          nb      = {cur, WLG'(b)};
          mask[b] = (nb >= lo) && (nb <= hi);
        end
        u_we = 1'b1;
        u_wa = cur;
        u_wd = set_mode ? (row_q | mask) : (row_q & ~mask);
        if (cur == hi[IX_W-1:WLG]) begin
          l_we       = 1'b1;
          l_wa       = lo[IDX_W-1:0];
          l_wd       = set_mode ? CNT_W'(need) : '0;
          state_next = ffcba_pkg::B_DONE;
        end else begin
          cur_next = cur + 1'b1;
          u_rd_en  = 1'b1;
          u_ra     = cur + 1'b1;
        end
      end
      ffcba_pkg::B_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_start_next  = ffcba_pkg::START_W'(res_start);
          out_count_next  = ffcba_pkg::COUNT_W'(res_count);
          state_next      = ffcba_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = ffcba_pkg::B_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/first_fit_contiguous_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Allocate: the map scan passes over a fully used (or fully free, still short) row of 64 nodes whole
//   and walks a mixed row one byte at a time; the found run is then marked one row at a time.
//   Free: the run is released one row at a time. Zero-size, oversize and out-of-range frees skip the map.
// Throughput: one request per back-end service; the front keeps accepting while the back works,
//   a two-entry command queue and the output register let both sides stall independently.
// Reset (rst, synchronous): a clearing pass over NODE_COUNT (16384) entries, s_tready low until done.
module first_fit_contiguous_block_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [20:0] size_bytes, [34:21] free_index, rest zero
  input  wire logic        s_tuser,   // [0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [13:0] start_index, [28:14] node_count, rest zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  logic               init_done;
  logic               f_valid, f_ready, q_valid, q_ready;
  ffcba_pkg::cmd_t    f_cmd, q_cmd;
  ffcba_pkg::status_t status;
  logic [ffcba_pkg::START_W-1:0] start_index;
  logic [ffcba_pkg::COUNT_W-1:0] node_count;

  ffcba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (init_done),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .func       (s_tuser),
    .size_bytes (s_tdata[20:0]),
    .free_index (s_tdata[34:21]),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  ffcba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  ffcba_back u_back (
    .clk        (clk),
    .rst        (rst),
    .init_done  (init_done),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status),
    .out_start  (start_index),
    .out_count  (node_count)
  );

  assign m_tdata = {3'b000, node_count, start_index};
  assign m_tuser = status;

endmodule
`default_nettype wire

[bench/first_fit_contiguous_block_allocator_tb.sv]
`timescale 1ns / 1ps
module first_fit_contiguous_block_allocator_tb;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } req_op_t;

  typedef struct packed {
    ffcba_pkg::status_t                 status;
    logic [ffcba_pkg::START_W-1:0]      start;
    logic [ffcba_pkg::COUNT_W-1:0]      count;
  } pool_result_t;

  typedef struct {
    req_op_t             op;
    int                  bytes;
    int                  idx;
    bit                  pinned;
    ffcba_pkg::status_t  status;
    int                  start;
    int                  count;
  } probe_row_t;

  localparam int POOL_BYTES   = ffcba_pkg::NODE_COUNT * ffcba_pkg::NODE_BYTES;
  localparam int PHASE_ITEMS  = 262;
  localparam int DRAIN_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [20:0] size_bytes, [34:21] free_index, rest zero
  logic        s_tuser = 1'b0; // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [13:0] start_index, [28:14] node_count, rest zero
  logic [1:0]  m_tuser;        // [1:0] status

  // pool image: run length at each run start, zero elsewhere
  int unsigned  run_len_at [ffcba_pkg::NODE_COUNT];
  int           live_starts [$];
  int           freed_starts [$];
  pool_result_t result_queue [$];

  // expectation typed in by a directed row, overrides the predictor
  bit           pin_valid = 1'b0;
  pool_result_t pinned;

  int unsigned  send_gap_pct = 0;
  int unsigned  stall_pct = 0;
  int           mismatches = 0;

  first_fit_contiguous_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  function automatic pool_result_t map_allocate(int unsigned bytes);
    pool_result_t r;
    int unsigned  need;
    int unsigned  span;
    int unsigned  i;
    r = '{ffcba_pkg::ST_NOSPACE, '0, '0};
    need = bytes / ffcba_pkg::NODE_BYTES + ((bytes % ffcba_pkg::NODE_BYTES) != 0 ? 1 : 0);
    if (need == 0) begin
      r.status = ffcba_pkg::ST_ZERO;
      return r;
    end
    if (need > ffcba_pkg::NODE_COUNT) return r;
    span = 0;
    i = 0;
    // used nodes are exactly the recorded runs, so hop over each run
    while (i < ffcba_pkg::NODE_COUNT) begin
      if (run_len_at[i] != 0) begin
        span = 0;
        i += run_len_at[i];
      end else begin
        span++;
        i++;
        if (span == need) begin
          run_len_at[i - need] = need;
          live_starts.push_back(i - need);
          r.status = ffcba_pkg::ST_OK;
          r.start  = ffcba_pkg::START_W'(i - need);
          r.count  = ffcba_pkg::COUNT_W'(need);
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic pool_result_t map_release(int unsigned idx);
    pool_result_t r;
    r = '{ffcba_pkg::ST_NOTSTART, '0, '0};
    if (idx >= ffcba_pkg::NODE_COUNT || run_len_at[idx] == 0) return r;
    r.status = ffcba_pkg::ST_OK;
    r.start  = ffcba_pkg::START_W'(idx);
    r.count  = ffcba_pkg::COUNT_W'(run_len_at[idx]);
    run_len_at[idx] = 0;
    for (int k = 0; k < live_starts.size(); k++) begin
      if (live_starts[k] == idx) begin
        live_starts.delete(k);
        break;
      end
    end
    freed_starts.push_back(idx);
    if (freed_starts.size() > 16) void'(freed_starts.pop_front());
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t: %s: got %0d, want %0d", $time, what, got_v, want_v);
    mismatches++;
  endtask

  // present one request and hold it until the transfer
  task automatic send_request(input req_op_t op, input int unsigned bytes,
                              input int unsigned idx);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'd0, idx[ffcba_pkg::FI_W-1:0], bytes[ffcba_pkg::BYTES_W-1:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // results first: a result never belongs to the request of the same edge
  always @(posedge clk) begin
    pool_result_t got;
    pool_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status = ffcba_pkg::status_t'(m_tuser);
        got.start  = m_tdata[13:0];
        got.count  = m_tdata[28:14];
        if (result_queue.size() == 0) begin
          flag_mismatch("result with nothing pending, start", got.start, -1);
        end else begin
          want = result_queue.pop_front();
          if (got.status != want.status)
            flag_mismatch("status", got.status, want.status);
          if (got.start != want.start)
            flag_mismatch("start_index", got.start, want.start);
          if (got.count != want.count)
            flag_mismatch("node_count", got.count, want.count);
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_FREE) want = map_release(s_tdata[34:21]);
        else                    want = map_allocate(s_tdata[20:0]);
        if (pin_valid) want = pinned;
        result_queue.push_back(want);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    probe_row_t  rows [$];
    probe_row_t  row;
    req_op_t     op;
    int unsigned bytes;
    int unsigned idx;
    int unsigned roll;

    // extremes, every status, whole-pool and last-node runs, double free
    rows.push_back('{OP_ALLOC, 0,             0,     1'b1, ffcba_pkg::ST_ZERO,     0,     0});
    rows.push_back('{OP_ALLOC, 1,             16383, 1'b1, ffcba_pkg::ST_OK,       0,     1});
    rows.push_back('{OP_ALLOC, 64,            0,     1'b1, ffcba_pkg::ST_OK,       1,     1});
    rows.push_back('{OP_ALLOC, 65,            0,     1'b1, ffcba_pkg::ST_OK,       2,     2});
    rows.push_back('{OP_FREE,  2097151,       0,     1'b1, ffcba_pkg::ST_OK,       0,     1});
    rows.push_back('{OP_FREE,  0,             0,     1'b1, ffcba_pkg::ST_NOTSTART, 0,     0});
    rows.push_back('{OP_FREE,  0,             3,     1'b1, ffcba_pkg::ST_NOTSTART, 0,     0});
    rows.push_back('{OP_ALLOC, 2097151,       16383, 1'b1, ffcba_pkg::ST_NOSPACE,  0,     0});
    rows.push_back('{OP_ALLOC, POOL_BYTES+1,  0,     1'b1, ffcba_pkg::ST_NOSPACE,  0,     0});
    rows.push_back('{OP_FREE,  0,             16383, 1'b1, ffcba_pkg::ST_NOTSTART, 0,     0});
    rows.push_back('{OP_FREE,  0,             2,     1'b1, ffcba_pkg::ST_OK,       2,     2});
    rows.push_back('{OP_FREE,  0,             1,     1'b1, ffcba_pkg::ST_OK,       1,     1});
    rows.push_back('{OP_ALLOC, POOL_BYTES,    16383, 1'b1, ffcba_pkg::ST_OK,       0, 16384});
    rows.push_back('{OP_ALLOC, 1,             0,     1'b1, ffcba_pkg::ST_NOSPACE,  0,     0});
    rows.push_back('{OP_FREE,  1048575,       0,     1'b1, ffcba_pkg::ST_OK,       0, 16384});
    rows.push_back('{OP_ALLOC, POOL_BYTES-64, 0,     1'b1, ffcba_pkg::ST_OK,       0, 16383});
    rows.push_back('{OP_ALLOC, 64,            0,     1'b1, ffcba_pkg::ST_OK,   16383,     1});
    rows.push_back('{OP_FREE,  0,             0,     1'b1, ffcba_pkg::ST_OK,       0, 16383});
    rows.push_back('{OP_ALLOC, 65,            8191,  1'b0, ffcba_pkg::ST_OK,       0,     0});
    rows.push_back('{OP_ALLOC, POOL_BYTES,    0,     1'b0, ffcba_pkg::ST_OK,       0,     0});
    rows.push_back('{OP_FREE,  0,             16383, 1'b0, ffcba_pkg::ST_OK,       0,     0});
    rows.push_back('{OP_FREE,  0,             0,     1'b0, ffcba_pkg::ST_OK,       0,     0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      row = rows[r];
      pin_valid = row.pinned;
      pinned = '{row.status, ffcba_pkg::START_W'(row.start), ffcba_pkg::COUNT_W'(row.count)};
      send_request(row.op, row.bytes, row.idx);
    end
    pin_valid = 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_gap_pct = 70;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 70;
        end
        default: begin
          send_gap_pct = 27;
          stall_pct = 27;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        // ignored fields carry random junk
        bytes = $urandom_range(2097151);
        idx = $urandom_range(16383);
        if ($urandom_range(99) < 55) begin
          op = OP_ALLOC;
          roll = $urandom_range(99);
          if (roll < 3)       bytes = 0;
          else if (roll < 78) bytes = $urandom_range(4096, 1);
          else if (roll < 90) bytes = $urandom_range(16384, 4097);
          else if (roll < 95) bytes = $urandom_range(2097151);
          else                bytes = $urandom_range(POOL_BYTES + 64, POOL_BYTES - 8192);
        end else begin
          op = OP_FREE;
          roll = $urandom_range(99);
          if (roll < 75 && live_starts.size() != 0)
            idx = live_starts[$urandom_range(live_starts.size() - 1)];
          else if (roll < 85 && freed_starts.size() != 0)
            idx = freed_starts[$urandom_range(freed_starts.size() - 1)];
        end
        send_request(op, bytes, idx);
      end
    end
    s_tvalid <= 1'b0;

    while (result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
src/ffcba_pkg.sv
src/ffcba_front.sv
src/ffcba_queue.sv
src/ffcba_back.sv
src/first_fit_contiguous_block_allocator.sv
bench/first_fit_contiguous_block_allocator_tb.sv
